// ----- hdl/tchc_pkg.sv -----
`timescale 1ns / 1ps

package tchc_pkg;

    // Field widths of the item and result words, the configuration registers and the APB port.
    localparam int VALUE_W = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 9;
    localparam int OUT_W   = 40;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPARE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_HSV_MODE    = 3'd0;
    localparam logic [2:0] REG_CUMULATIVE  = 3'd1;
    localparam logic [2:0] REG_BINS_FIRST  = 3'd2;
    localparam logic [2:0] REG_BINS_SECOND = 3'd3;
    localparam logic [2:0] REG_BINS_THIRD  = 3'd4;

    // Value spans that are split into bins.
    localparam logic [CFG_W-1:0] SPAN_HUE  = 9'd180;
    localparam logic [CFG_W-1:0] SPAN_FULL = 9'd256;

    // A bin count of zero acts as one, and one above the maximum acts as the maximum.
    function automatic logic [CFG_W-1:0] clamp_bins(input logic [CFG_W-1:0] b,
                                                   input logic [CFG_W-1:0] maxb);
        logic [CFG_W-1:0] r;
        if (b == '0)
            r = 9'd1;
        else if (b > maxb)
            r = maxb;
        else
            r = b;
        return r;
    endfunction

endpackage

// ----- hdl/tchc_if.sv -----
`timescale 1ns / 1ps

// Input word: one clear, add or compare command.
interface tchc_item_if;
    import tchc_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic               bank;
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] second_value;
    logic [VALUE_W-1:0] third_value;

    modport source (output valid, kind, bank, first_value, second_value, third_value,
                    input ready);
    modport sink   (input valid, kind, bank, first_value, second_value, third_value,
                    output ready);
endinterface

// Output word: three distances and the bank empty flags.
interface tchc_result_if;
    import tchc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] distance_first;
    logic [OUT_W-1:0] distance_second;
    logic [OUT_W-1:0] distance_third;
    logic             bank0_empty;
    logic             bank1_empty;

    modport source (output valid, distance_first, distance_second, distance_third,
                    bank0_empty, bank1_empty, input ready);
    modport sink   (input valid, distance_first, distance_second, distance_third,
                    bank0_empty, bank1_empty, output ready);
endinterface

// ----- hdl/tchc_ram.sv -----
`timescale 1ns / 1ps

module tchc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/tchc_div.sv -----
`timescale 1ns / 1ps

module tchc_div #(
    parameter int DW = 48,
    parameter int VW = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DW-1:0]           dividend,
    input  logic [VW-1:0]           divisor,
    input  logic [$clog2(DW+1)-1:0] steps,
    output logic                    busy,
    output logic                    done,
    output logic [DW-1:0]           quotient
);

    localparam int SW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    // One quotient bit a cycle; the dividend is left aligned so that only
    // its meaningful top bits are walked.
    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            dvd_next  = dividend;
            dsr_next  = divisor;
            quo_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            if (!diff[VW])
            begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - SW'(1);
            if (cnt_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/three_channel_histogram_compare.sv -----
`timescale 1ns / 1ps

// Channel   Role     Handshake        Word
// pixel     sink     valid / ready    kind, bank, three 8-bit channel samples
// result    source   valid / ready    three 40-bit distances, two empty flags
// APB       slave    psel / penable   five registers at byte offsets 0..16
//
// After reset the block zeroes both banks, one entry of each a cycle, walking
// all 3*MAX_BINS entries (768 by default) before it takes a word.
// A clear walks all 3*MAX_BINS entries of one bank. An add does, per channel,
// two serial divisions (bin width, then bin index) and a read and write of one
// counter. A compare reads one bin of both banks per step; the normalized
// method runs one serial division per bin, the cumulative method keeps a
// running sum and runs one final division per channel.
// A pending result does not stop the next word from being taken.

module three_channel_histogram_compare #(
    parameter int MAX_BINS    = 256,
    parameter int COUNT_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tchc_item_if.sink                    pixel,
    tchc_result_if.source                result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tchc_pkg::APB_AW-1:0]  paddr,
    input  logic [tchc_pkg::APB_DW-1:0]  pwdata,
    output logic [tchc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    import tchc_pkg::*;

    localparam int CW     = COUNT_WIDTH;
    localparam int LB     = $clog2(MAX_BINS);
    localparam int BIN_W  = $clog2(MAX_BINS + 1);
    localparam int DEPTH  = 3 * MAX_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = CW + 2 * LB;
    localparam int DW     = SUM_W + FRAC_BITS;
    localparam int VW     = CW + 1;
    localparam int SW     = $clog2(DW + 1);
    localparam int RUN_W  = CW + LB + 1;
    localparam int EW     = (DW > OUT_W) ? DW : OUT_W;

    localparam logic [4:0] S_INIT      = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_CLR       = 5'd2;
    localparam logic [4:0] S_ADD_SPAN  = 5'd3;
    localparam logic [4:0] S_ADD_SPANW = 5'd4;
    localparam logic [4:0] S_ADD_IDX   = 5'd5;
    localparam logic [4:0] S_ADD_IDXW  = 5'd6;
    localparam logic [4:0] S_ADD_RD    = 5'd7;
    localparam logic [4:0] S_ADD_WR    = 5'd8;
    localparam logic [4:0] S_CMP_RD    = 5'd9;
    localparam logic [4:0] S_CMP_DATA  = 5'd10;
    localparam logic [4:0] S_CMP_DIVW  = 5'd11;
    localparam logic [4:0] S_CMP_FIN   = 5'd12;
    localparam logic [4:0] S_CMP_FINW  = 5'd13;
    localparam logic [4:0] S_CMP_NEXT  = 5'd14;
    localparam logic [4:0] S_OUT       = 5'd15;

    // Configuration registers.
    logic             hsv_reg, cum_reg;
    logic [CFG_W-1:0] bins_reg [3];
    logic             cfg_we;
    logic [2:0]       cfg_idx;

    // Control state.
    logic [4:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              bank_reg, bank_next;
    logic [1:0]        ch_reg, ch_next;
    logic [LB-1:0]     bin_reg, bin_next;
    logic [LB-1:0]     idx_reg, idx_next;
    logic [CFG_W-1:0]  wdiv_reg, wdiv_next;
    logic [1:0]        empty_reg, empty_next;
    logic              ov_reg, ov_next;

    // Datapath state.
    logic [VALUE_W-1:0]      val_reg [3];
    logic [VALUE_W-1:0]      val_next [3];
    logic [OUT_W-1:0]        acc_reg, acc_next;
    logic signed [RUN_W-1:0] run_reg, run_next;
    logic [SUM_W-1:0]        csum_reg, csum_next;
    logic [OUT_W-1:0]        dist_reg [3];
    logic [OUT_W-1:0]        dist_next [3];
    logic [OUT_W-1:0]        res_reg [3];
    logic [OUT_W-1:0]        res_next [3];
    logic [1:0]              rempty_reg, rempty_next;

    // Memory and divider hookup.
    logic              we0, we1;
    logic [ADDR_W-1:0] waddr, raddr, addr_cur;
    logic [CW-1:0]     wdata, rd0, rd1;
    logic              div_start, div_busy, div_done;
    logic [DW-1:0]     div_dvd, div_quo;
    logic [VW-1:0]     div_dsr;
    logic [SW-1:0]     div_steps;

    // Per-channel helpers.
    logic [BIN_W-1:0]   bcur;
    logic [CFG_W-1:0]   bcur9;
    logic [CFG_W-1:0]   span;
    logic [VALUE_W-1:0] vcur;
    logic               last_bin;
    logic [CW-1:0]      dabs;
    logic [CW:0]        dsum;
    logic signed [RUN_W-1:0] run_step;
    logic [RUN_W-2:0]   run_abs;
    logic [OUT_W:0]     acc_add;
    logic [EW-1:0]      qx;
    logic [CFG_W-1:0]   idx_cand;

    assign pixel.ready = (state_reg == S_IDLE);
    logic acc_in;
    assign acc_in = pixel.valid && pixel.ready;

    // Configuration port: writes complete in the access phase.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            REG_HSV_MODE:    prdata = APB_DW'(hsv_reg);
            REG_CUMULATIVE:  prdata = APB_DW'(cum_reg);
            REG_BINS_FIRST:  prdata = APB_DW'(bins_reg[0]);
            REG_BINS_SECOND: prdata = APB_DW'(bins_reg[1]);
            REG_BINS_THIRD:  prdata = APB_DW'(bins_reg[2]);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_reg     <= 1'b1;
            cum_reg     <= 1'b0;
            bins_reg[0] <= 9'd18;
            bins_reg[1] <= 9'd16;
            bins_reg[2] <= 9'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_HSV_MODE:    hsv_reg     <= pwdata[0];
                REG_CUMULATIVE:  cum_reg     <= pwdata[0];
                REG_BINS_FIRST:  bins_reg[0] <= pwdata[CFG_W-1:0];
                REG_BINS_SECOND: bins_reg[1] <= pwdata[CFG_W-1:0];
                REG_BINS_THIRD:  bins_reg[2] <= pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective bin count, span and sample of the current channel.
    always_comb
    begin
        case (ch_reg)
            2'd0:    bcur9 = clamp_bins(bins_reg[0], CFG_W'(MAX_BINS));
            2'd1:    bcur9 = clamp_bins(bins_reg[1], CFG_W'(MAX_BINS));
            default: bcur9 = clamp_bins(bins_reg[2], CFG_W'(MAX_BINS));
        endcase
        case (ch_reg)
            2'd0:    vcur = val_reg[0];
            2'd1:    vcur = val_reg[1];
            default: vcur = val_reg[2];
        endcase
        span = (ch_reg == 2'd0 && hsv_reg) ? SPAN_HUE : SPAN_FULL;
    end
    assign bcur     = BIN_W'(bcur9);
    assign last_bin = (BIN_W'(bin_reg) == bcur - BIN_W'(1));

    // Entry of the current channel: the add index or the compare bin.
    assign addr_cur = ADDR_W'(ch_reg) * ADDR_W'(MAX_BINS)
                    + ADDR_W'((state_reg == S_ADD_RD || state_reg == S_ADD_WR)
                              ? idx_reg : bin_reg);

    // Bin difference terms.
    assign dabs     = (rd0 > rd1) ? (rd0 - rd1) : (rd1 - rd0);
    assign dsum     = (CW+1)'(rd0) + (CW+1)'(rd1) + (CW+1)'(1);
    assign run_step = run_reg + RUN_W'($signed({1'b0, rd1})) - RUN_W'($signed({1'b0, rd0}));
    assign run_abs  = run_step[RUN_W-1] ? (RUN_W-1)'(-run_step) : run_step[RUN_W-2:0];
    assign acc_add  = {1'b0, acc_reg} + (OUT_W+1)'(div_quo);
    assign qx       = EW'(div_quo);
    assign idx_cand = {1'b0, div_quo[VALUE_W-1:0]};

    // Divider requests.
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = '0;
        div_steps = '0;
        case (state_reg)
            S_ADD_SPAN:
            begin
                div_start = 1'b1;
                div_dvd   = DW'(span) << (DW - CFG_W);
                div_dsr   = VW'(bcur);
                div_steps = SW'(CFG_W);
            end
            S_ADD_IDX:
            begin
                div_start = 1'b1;
                div_dvd   = DW'(vcur) << (DW - VALUE_W);
                div_dsr   = VW'(wdiv_reg);
                div_steps = SW'(VALUE_W);
            end
            S_CMP_DATA:
            begin
                div_start = !cum_reg;
                div_dvd   = DW'({dabs, {FRAC_BITS{1'b0}}}) << (DW - CW - FRAC_BITS);
                div_dsr   = dsum;
                div_steps = SW'(CW + FRAC_BITS);
            end
            S_CMP_FIN:
            begin
                div_start = 1'b1;
                div_dvd   = {csum_reg, {FRAC_BITS{1'b0}}};
                div_dsr   = VW'(bcur);
                div_steps = SW'(DW);
            end
            default: ;
        endcase
    end

    // Memory ports.
    always_comb
    begin
        we0   = 1'b0;
        we1   = 1'b0;
        waddr = addr_cur;
        wdata = '0;
        raddr = addr_cur;
        case (state_reg)
            S_INIT:
            begin
                we0   = 1'b1;
                we1   = 1'b1;
                waddr = clr_reg;
            end
            S_CLR:
            begin
                we0   = !bank_reg;
                we1   = bank_reg;
                waddr = clr_reg;
            end
            S_ADD_WR:
            begin
                we0 = !bank_reg;
                we1 = bank_reg;
                if (bank_reg)
                    wdata = (&rd1) ? rd1 : rd1 + CW'(1);
                else
                    wdata = (&rd0) ? rd0 : rd0 + CW'(1);
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        bank_next   = bank_reg;
        ch_next     = ch_reg;
        bin_next    = bin_reg;
        idx_next    = idx_reg;
        wdiv_next   = wdiv_reg;
        empty_next  = empty_reg;
        ov_next     = ov_reg;
        val_next    = val_reg;
        acc_next    = acc_reg;
        run_next    = run_reg;
        csum_next   = csum_reg;
        dist_next   = dist_reg;
        res_next    = res_reg;
        rempty_next = rempty_reg;

        if (result.valid && result.ready)
            ov_next = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (acc_in)
                begin
                    bank_next   = pixel.bank;
                    val_next[0] = pixel.first_value;
                    val_next[1] = pixel.second_value;
                    val_next[2] = pixel.third_value;
                    ch_next     = 2'd0;
                    bin_next    = '0;
                    clr_next    = '0;
                    acc_next    = '0;
                    run_next    = '0;
                    csum_next   = '0;
                    case (pixel.kind)
                        KIND_CLEAR:
                        begin
                            empty_next[pixel.bank] = 1'b1;
                            state_next = S_CLR;
                        end
                        KIND_ADD:     state_next = S_ADD_SPAN;
                        KIND_COMPARE: state_next = S_CMP_RD;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_CLR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_ADD_SPAN: state_next = S_ADD_SPANW;
            S_ADD_SPANW:
            begin
                if (div_done)
                begin
                    wdiv_next  = (div_quo[CFG_W-1:0] == '0) ? CFG_W'(1) : div_quo[CFG_W-1:0];
                    state_next = S_ADD_IDX;
                end
            end
            S_ADD_IDX: state_next = S_ADD_IDXW;
            S_ADD_IDXW:
            begin
                if (div_done)
                begin
                    if (idx_cand >= bcur9)
                        idx_next = LB'(bcur9 - CFG_W'(1));
                    else
                        idx_next = LB'(idx_cand);
                    state_next = S_ADD_RD;
                end
            end
            S_ADD_RD: state_next = S_ADD_WR;
            S_ADD_WR:
            begin
                if (ch_reg == 2'd2)
                begin
                    empty_next[bank_reg] = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_ADD_SPAN;
                end
            end
            S_CMP_RD: state_next = S_CMP_DATA;
            S_CMP_DATA:
            begin
                if (cum_reg)
                begin
                    run_next   = run_step;
                    csum_next  = csum_reg + SUM_W'(run_abs);
                    state_next = S_CMP_NEXT;
                end
                else
                begin
                    state_next = S_CMP_DIVW;
                end
            end
            S_CMP_DIVW:
            begin
                if (div_done)
                begin
                    acc_next   = acc_add[OUT_W] ? OUT_MAX : acc_add[OUT_W-1:0];
                    state_next = S_CMP_NEXT;
                end
            end
            S_CMP_NEXT:
            begin
                if (!last_bin)
                begin
                    bin_next   = bin_reg + LB'(1);
                    state_next = S_CMP_RD;
                end
                else if (cum_reg)
                begin
                    state_next = S_CMP_FIN;
                end
                else
                begin
                    dist_next[ch_reg] = acc_reg;
                    bin_next  = '0;
                    acc_next  = '0;
                    ch_next   = ch_reg + 2'd1;
                    state_next = (ch_reg == 2'd2) ? S_OUT : S_CMP_RD;
                end
            end
            S_CMP_FIN: state_next = S_CMP_FINW;
            S_CMP_FINW:
            begin
                if (div_done)
                begin
                    dist_next[ch_reg] = (qx > EW'(OUT_MAX)) ? OUT_MAX : OUT_W'(qx);
                    bin_next   = '0;
                    run_next   = '0;
                    csum_next  = '0;
                    ch_next    = ch_reg + 2'd1;
                    state_next = (ch_reg == 2'd2) ? S_OUT : S_CMP_RD;
                end
            end
            S_OUT:
            begin
                // Wait for the output register to be free.
                if (!ov_next)
                begin
                    ov_next     = 1'b1;
                    res_next    = dist_reg;
                    rempty_next = empty_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            clr_reg   <= '0;
            bank_reg  <= 1'b0;
            ch_reg    <= 2'd0;
            bin_reg   <= '0;
            empty_reg <= 2'b11;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            bank_reg  <= bank_next;
            ch_reg    <= ch_next;
            bin_reg   <= bin_next;
            empty_reg <= empty_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        wdiv_reg   <= wdiv_next;
        val_reg    <= val_next;
        acc_reg    <= acc_next;
        run_reg    <= run_next;
        csum_reg   <= csum_next;
        dist_reg   <= dist_next;
        res_reg    <= res_next;
        rempty_reg <= rempty_next;
    end

    // Result word.
    assign result.valid           = ov_reg;
    assign result.distance_first  = res_reg[0];
    assign result.distance_second = res_reg[1];
    assign result.distance_third  = res_reg[2];
    assign result.bank0_empty     = rempty_reg[0];
    assign result.bank1_empty     = rempty_reg[1];

    // Bank 0 and bank 1 counters.
    tchc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd0)
    );

    tchc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd1)
    );

    // Shared serial divider.
    tchc_div #(.DW(DW), .VW(VW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .steps    (div_steps),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Counters are written only by the clearing walks and the add write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (we0 || we1) |-> (state_reg == S_INIT || state_reg == S_CLR || state_reg == S_ADD_WR))
        else $error("counter write outside clear or add");

    // Both banks are written together only during the reset clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (we0 && we1) |-> (state_reg == S_INIT))
        else $error("both banks written outside reset clear");

    // The divider is never restarted while a division is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // A new result appears only when a compare finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside compare end");

    // The last channel of an add marks its bank as holding pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD_WR && ch_reg == 2'd2) |=> !empty_reg[$past(bank_reg)])
        else $error("bank still empty after add");

endmodule
